### src/plwe_pkg.sv
// ----------------------------------------------------------------------------
// plwe_pkg
// Shared command and status types of the packet loss window estimator.
// ----------------------------------------------------------------------------
package plwe_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned SpanW   = 31;
  localparam int unsigned FracW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxEnt = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinEnt = 2'd2;

  localparam logic CmdArrival = 1'b0;
  localparam logic CmdQuery   = 1'b1;

  typedef struct packed {
    logic load;
    logic k_clr;
    logic k_inc;
    logic k_dec;
    logic rd_k;
    logic rd_jm1;
    logic rd_head;
    logic drop;
    logic j_init;
    logic wr_j;
    logic wr_new;
    logic wr_time;
    logic span_load;
    logic div_step;
    logic out_load;
  } plwe_cmd_t;

  typedef struct packed {
    logic is_query;
    logic k_lt_cnt;
    logic rd_eq;
    logic rd_ge;
    logic full;
    logic k_nz;
    logic j_gt_k;
    logic cnt_nz;
    logic ev_cond;
    logic ok_query;
    logic div_last;
    logic out_busy;
  } plwe_sts_t;

endpackage

### src/plwe_ctrl.sv
// ----------------------------------------------------------------------------
// plwe_ctrl
// Sequencer: sorted search, shift insert, eviction walk and query divide.
// ----------------------------------------------------------------------------
module plwe_ctrl import plwe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  plwe_sts_t sts_i,
  output plwe_cmd_t cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSrd   = 4'd1;
  localparam logic [3:0] StScmp  = 4'd2;
  localparam logic [3:0] StIns   = 4'd3;
  localparam logic [3:0] StJinit = 4'd4;
  localparam logic [3:0] StShRd  = 4'd5;
  localparam logic [3:0] StShWr  = 4'd6;
  localparam logic [3:0] StEvRd  = 4'd7;
  localparam logic [3:0] StEvChk = 4'd8;
  localparam logic [3:0] StFin   = 4'd9;
  localparam logic [3:0] StSpan  = 4'd10;
  localparam logic [3:0] StDiv   = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.k_clr = 1'b1;
          state_d     = StSrd;
        end
      end
      StSrd: begin
        if (sts_i.is_query) begin
          state_d = StEvRd;
        end else if (sts_i.k_lt_cnt) begin
          cmd_o.rd_k = 1'b1;
          state_d    = StScmp;
        end else begin
          state_d = StIns;
        end
      end
      StScmp: begin
        if (sts_i.rd_eq) begin
          cmd_o.wr_time = 1'b1;
          state_d       = StEvRd;
        end else if (sts_i.rd_ge) begin
          state_d = StIns;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = StSrd;
        end
      end
      StIns: begin
        if (sts_i.full) begin
          cmd_o.drop  = 1'b1;
          cmd_o.k_dec = sts_i.k_nz;
        end
        state_d = StJinit;
      end
      StJinit: begin
        cmd_o.j_init = 1'b1;
        state_d      = StShRd;
      end
      StShRd: begin
        if (sts_i.j_gt_k) begin
          cmd_o.rd_jm1 = 1'b1;
          state_d      = StShWr;
        end else begin
          cmd_o.wr_new = 1'b1;
          state_d      = StEvRd;
        end
      end
      StShWr: begin
        cmd_o.wr_j = 1'b1;
        state_d    = StShRd;
      end
      StEvRd: begin
        if (sts_i.cnt_nz) begin
          cmd_o.rd_head = 1'b1;
          state_d       = StEvChk;
        end else begin
          state_d = StFin;
        end
      end
      StEvChk: begin
        if (sts_i.ev_cond) begin
          cmd_o.drop = 1'b1;
          state_d    = StEvRd;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!sts_i.is_query) begin
          state_d = StIdle;
        end else if (!sts_i.ok_query) begin
          state_d = StOut;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = StSpan;
        end
      end
      StSpan: begin
        cmd_o.span_load = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/plwe_dp.sv
// ----------------------------------------------------------------------------
// plwe_dp
// Datapath: unwrap, sorted circular table, config registers, divider, output.
// ----------------------------------------------------------------------------
module plwe_dp import plwe_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ID_WIDTH    = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_cmd_i,
  input  logic [SeqW-1:0]     in_seq_i,
  input  logic [TimeW-1:0]    in_now_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FracW-1:0]    out_frac_o,
  output logic [SpanW-1:0]    out_span_o,
  output logic                out_status_o,
  input  plwe_cmd_t           cmd_i,
  output plwe_sts_t           sts_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW   = ID_WIDTH + TimeW;
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;
  localparam int unsigned NW   = SpanW + FracW;
  localparam logic [ID_WIDTH-1:0] IdMax   = '1;
  localparam logic [SpanW-1:0]    SpanSat = '1;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_q;

  logic [15:0]         window_q;
  logic [7:0]          max_ent_q, min_ent_q;
  logic                seen_q, query_q;
  logic [SeqW-1:0]     last_seq_q;
  logic [ID_WIDTH-1:0] last_id_q, max_id_q, id_q;
  logic [TimeW-1:0]    now_q;
  logic [AW-1:0]       head_q;
  logic [CW-1:0]       cnt_q, k_q, j_q;
  logic [NW-1:0]       rem_q;
  logic [SpanW-1:0]    span_q;
  logic [FracW-1:0]    quot_q;
  logic [2:0]          bit_q;
  logic                out_valid_q;
  logic [FracW-1:0]    out_frac_q;
  logic [SpanW-1:0]    out_span_q;
  logic                out_status_q;

  function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] k);
    logic [AW+1:0] s;
    s = {2'b0, h} + (AW+2)'(k);
    if (s >= (AW+2)'(TABLE_DEPTH)) begin
      s = s - (AW+2)'(TABLE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // unwrap
  logic [SeqW-1:0]     d_seq;
  logic [ID_WIDTH-1:0] room, new_id;
  logic [SeqW:0]       back;
  always_comb begin
    d_seq = in_seq_i - last_seq_q;
    room  = IdMax - last_id_q;
    back  = 17'h10000 - {1'b0, d_seq};
    if (!seen_q) begin
      new_id = ID_WIDTH'(in_seq_i);
    end else if (!d_seq[SeqW-1]) begin
      new_id = (ID_WIDTH'(d_seq) > room) ? IdMax : last_id_q + ID_WIDTH'(d_seq);
    end else begin
      new_id = (last_id_q < ID_WIDTH'(back)) ? '0 : last_id_q - ID_WIDTH'(back);
    end
  end

  logic [ID_WIDTH-1:0] r_id;
  logic [TimeW-1:0]    r_time;
  logic [TimeW:0]      r_limit;
  assign r_id    = rd_q[EW-1:TimeW];
  assign r_time  = rd_q[TimeW-1:0];
  assign r_limit = {1'b0, r_time} + (TimeW+1)'(window_q);

  // span and divider
  logic [ID_WIDTH-1:0] diff;
  logic [SpanW-1:0]    span_n;
  logic [NW-1:0]       trial;
  assign diff   = max_id_q - r_id;
  assign span_n = (diff >= ID_WIDTH'(SpanSat)) ? SpanSat : SpanW'(diff + 1'b1);
  assign trial  = NW'(span_q) << bit_q;

  always_comb begin
    sts_o          = '0;
    sts_o.is_query = query_q;
    sts_o.k_lt_cnt = (k_q < cnt_q);
    sts_o.rd_eq    = (r_id == id_q);
    sts_o.rd_ge    = (r_id >= id_q);
    sts_o.full     = (cnt_q == CW'(TABLE_DEPTH));
    sts_o.k_nz     = (k_q != '0);
    sts_o.j_gt_k   = (j_q > k_q);
    sts_o.cnt_nz   = (cnt_q != '0);
    sts_o.ev_cond  = (CMPW'(cnt_q) > CMPW'(max_ent_q)) || (r_limit < {1'b0, now_q});
    sts_o.ok_query = seen_q && (cnt_q != '0) && (CMPW'(cnt_q) >= CMPW'(min_ent_q));
    sts_o.div_last = (bit_q == 3'd0);
    sts_o.out_busy = out_valid_q;
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_j) begin
      mem[phys(head_q, j_q)] <= rd_q;
    end else if (cmd_i.wr_new || cmd_i.wr_time) begin
      mem[phys(head_q, k_q)] <= {id_q, now_q};
    end
    if (cmd_i.rd_k) begin
      rd_q <= mem[phys(head_q, k_q)];
    end else if (cmd_i.rd_jm1) begin
      rd_q <= mem[phys(head_q, j_q - 1'b1)];
    end else if (cmd_i.rd_head) begin
      rd_q <= mem[head_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q  <= new_id;
      now_q <= in_now_i;
    end
    if (cmd_i.j_init) begin
      j_q <= cnt_q;
    end else if (cmd_i.wr_j) begin
      j_q <= j_q - 1'b1;
    end
    if (cmd_i.span_load) begin
      span_q <= span_n;
      quot_q <= '0;
      bit_q  <= 3'd7;
      if (CW'(span_n) > cnt_q || span_n > SpanW'(cnt_q)) begin
        rem_q <= (NW'(span_n) << FracW) - NW'(span_n) - ((NW'(cnt_q) << FracW) - NW'(cnt_q));
      end else begin
        rem_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      bit_q <= bit_q - 1'b1;
      if (rem_q >= trial) begin
        rem_q         <= rem_q - trial;
        quot_q[bit_q] <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_frac_q   <= sts_o.ok_query ? quot_q : '0;
      out_span_q   <= sts_o.ok_query ? span_q : '0;
      out_status_q <= !sts_o.ok_query;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= 16'd4000;
      max_ent_q   <= 8'd200;
      min_ent_q   <= 8'd100;
      seen_q      <= 1'b0;
      query_q     <= 1'b0;
      last_seq_q  <= '0;
      last_id_q   <= '0;
      max_id_q    <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWindow: window_q  <= cfg_data_i;
          CfgMaxEnt: max_ent_q <= cfg_data_i[7:0];
          CfgMinEnt: min_ent_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        query_q <= (in_cmd_i == CmdQuery);
        if (in_cmd_i == CmdArrival) begin
          last_seq_q <= in_seq_i;
          last_id_q  <= new_id;
          seen_q     <= 1'b1;
          if (!seen_q || new_id > max_id_q) begin
            max_id_q <= new_id;
          end
        end
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end else if (cmd_i.k_dec) begin
        k_q <= k_q - 1'b1;
      end
      if (cmd_i.drop) begin
        head_q <= (head_q == AW'(TABLE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
      end else if (cmd_i.wr_new) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_frac_o   = out_frac_q;
  assign out_span_o   = out_span_q;
  assign out_status_o = out_status_q;

endmodule

### src/packet_loss_window_estimator.sv
// ----------------------------------------------------------------------------
// packet_loss_window_estimator
// Receive-side loss estimator over a sliding window of packet arrivals.
// ----------------------------------------------------------------------------
// Input words carry an arrival (tuser 0) or a loss query (tuser 1). An arrival
// produces no output word; a query produces one output word with the loss
// fraction, the id span and a status flag in tuser (1 = not enough data).
// One word is processed at a time; s_axis_tready is high only between words.
// The single-port table sets the timing. An arrival always searches from the
// oldest id, reading one stored entry per step, shifts the later entries up
// to make room for a new id (a repeated id only gets its time rewritten), and
// then checks and evicts entries from the head of the table.
// A query runs the same eviction walk, then loads the span and runs the
// 8-step divider; the span and divider are skipped if there is not enough data.
// The result sits in an output register; if the sink stalls, a finished
// query waits there and the next word may still be accepted, but a further
// query holds until the register drains.
// Reset restores the config defaults (window 4000 ms, max 200, min 100) and
// empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module packet_loss_window_estimator import plwe_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned ID_WIDTH    = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // seq_num[15:0], now_ms[63:16]
  input  logic               s_axis_tuser,  // cmd
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,  // loss_fraction[7:0], span_count[38:8], 0
  output logic               m_axis_tuser   // status
);

  plwe_cmd_t        cmd;
  plwe_sts_t        sts;
  logic [FracW-1:0] frac;
  logic [SpanW-1:0] span;

  plwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plwe_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_seq_i     (s_axis_tdata[15:0]),
    .in_now_i     (s_axis_tdata[63:16]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_frac_o   (frac),
    .out_span_o   (span),
    .out_status_o (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  assign m_axis_tdata = {1'b0, span, frac};

endmodule

### tb/plwe_loss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwe_loss_checker
// Watches the config port and both streams of the loss estimator, keeps its
// own copy of the sorted arrival table, predicts each query result and
// compares it field by field with the output word.
// ----------------------------------------------------------------------------
module plwe_loss_checker import plwe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [63:0]        s_data_i,
  input  logic               s_user_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [39:0]        m_data_i,
  input  logic               m_user_i,
  output int unsigned        fail_cnt_o,
  output int unsigned        pending_o
);

  localparam int unsigned Depth = 256;
  localparam logic [63:0] IdMask  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] SpanMax = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [FracW-1:0] frac;
    logic [SpanW-1:0] span;
    logic             status;
  } loss_est_t;

  logic [63:0] id_store   [Depth+1];
  logic [63:0] time_store [Depth+1];
  int unsigned fill;
  logic [63:0] top_id;
  logic        seen;
  logic [15:0] prev_seq;
  logic [63:0] prev_id;
  logic [15:0] win_ms;
  logic [7:0]  cap;
  logic [7:0]  need;
  loss_est_t   est_q[$];

  initial begin
    fill = 0; top_id = '0; seen = 1'b0; prev_seq = '0; prev_id = '0;
    win_ms = 16'd4000; cap = 8'd200; need = 8'd100; fail_cnt_o = 0;
    pending_o = 0;
  end

  task automatic drop_oldest();
    if (fill != 0) begin
      for (int i = 0; i + 1 < fill; i++) begin
        id_store[i]   = id_store[i+1];
        time_store[i] = time_store[i+1];
      end
      fill--;
    end
  endtask

  task automatic age_out(input logic [63:0] now);
    while (fill > 0 && (fill > cap || time_store[0] + win_ms < now)) drop_oldest();
  endtask

  function automatic logic [63:0] widen_seq(input logic [15:0] seq);
    logic [15:0] d;
    logic [63:0] id;
    d = seq - prev_seq;
    if (!seen) id = {48'd0, seq};
    else if (d < 16'h8000) id = (d > IdMask - prev_id) ? IdMask : prev_id + d;
    else id = (prev_id < 64'h10000 - d) ? 64'd0 : prev_id - (64'h10000 - d);
    return id;
  endfunction

  task automatic record_arrival(input logic [63:0] id, input logic [63:0] t);
    int unsigned pos;
    pos = 0;
    while (pos < fill && id_store[pos] < id) pos++;
    if (pos < fill && id_store[pos] == id) begin
      time_store[pos] = t;
    end else begin
      if (fill >= Depth) begin
        drop_oldest();
        if (pos > 0) pos--;
      end
      for (int i = fill; i > pos; i--) begin
        id_store[i]   = id_store[i-1];
        time_store[i] = time_store[i-1];
      end
      id_store[pos] = id; time_store[pos] = t;
      fill++;
    end
  endtask

  always @(posedge clk_i) begin
    logic [63:0] now, id, diff, span, frac;
    loss_est_t   est, got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWindow: win_ms = cfg_data_i;
          CfgMaxEnt: cap    = cfg_data_i[7:0];
          CfgMinEnt: need   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        now = {16'd0, s_data_i[63:16]};
        if (s_user_i == CmdArrival) begin
          id = widen_seq(s_data_i[15:0]);
          prev_seq = s_data_i[15:0];
          prev_id  = id;
          if (!seen || id > top_id) top_id = id;
          seen = 1'b1;
          record_arrival(id, now);
          age_out(now);
        end else begin
          age_out(now);
          est = '{frac: '0, span: '0, status: 1'b1};
          if (seen && fill != 0 && fill >= need) begin
            diff = top_id - id_store[0];
            span = (diff >= SpanMax) ? SpanMax : diff + 1;
            frac = (span > fill) ? (span - fill) * 255 / span : 64'd0;
            est = '{frac: frac[7:0], span: span[30:0], status: 1'b0};
          end
          est_q.push_back(est);
        end
      end
      if (m_valid_i && m_ready_i) begin
        got = '{frac: m_data_i[7:0], span: m_data_i[38:8], status: m_user_i};
        if (est_q.size() == 0) begin
          $error("unexpected output word: frac %0d span %0d status %0d",
                 got.frac, got.span, got.status);
          fail_cnt_o++;
        end else begin
          est = est_q.pop_front();
          if (got.frac != est.frac) begin
            $error("loss_fraction: expected %0d, got %0d", est.frac, got.frac);
            fail_cnt_o++;
          end
          if (got.span != est.span) begin
            $error("span_count: expected %0d, got %0d", est.span, got.span);
            fail_cnt_o++;
          end
          if (got.status != est.status) begin
            $error("status: expected %0d, got %0d", est.status, got.status);
            fail_cnt_o++;
          end
        end
      end
      pending_o = est_q.size();
    end
  end

endmodule

### tb/tb_packet_loss_window_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_loss_window_estimator
// Drives arrivals and loss queries into the estimator: a directed set for
// sequence wrap, clamping, duplicates and eviction, then random phases of
// mostly in-order traffic under several table settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_packet_loss_window_estimator;
  import plwe_pkg::*;

  localparam int unsigned DrainCycles = 600;
  localparam int unsigned StallLimit  = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = CmdArrival;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;
  logic               m_axis_tuser;
  int unsigned        fail_cnt, pending, quiet;
  int unsigned        idle_pct = 0, stall_pct = 0;
  logic [47:0]        clock_ms;
  logic [15:0]        seq;

  always #10 clk_i = ~clk_i;

  packet_loss_window_estimator u_dut (.*);

  plwe_loss_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [15:0] sq, input logic [47:0] t);
    int unsigned gaps;
    gaps = 0;
    while ($urandom_range(99) < idle_pct) gaps++;
    if (gaps != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {t, sq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [15:0] win, input logic [7:0] mx, input logic [7:0] mn);
    cfg_we_i <= 1'b1; cfg_idx_i <= CfgWindow; cfg_data_i <= win;
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxEnt; cfg_data_i <= {8'd0, mx};
    @(posedge clk_i);
    cfg_idx_i <= CfgMinEnt; cfg_data_i <= {8'd0, mn};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) clock_ms = 48'({$urandom, $urandom});
      else if (r < 5) clock_ms = clock_ms + 48'($urandom_range(5000, 70000));
      else clock_ms = clock_ms + 48'($urandom_range(0, 40));
      if ($urandom_range(99) < 25) begin
        send_word(CmdQuery, 16'($urandom), clock_ms);
      end else begin
        r = $urandom_range(99);
        if (r < 65) seq = seq + 16'd1;
        else if (r < 80) seq = seq + 16'($urandom_range(2, 20));
        else if (r < 90) seq = seq - 16'($urandom_range(1, 10));
        else if (r < 95) seq = seq;
        else seq = 16'($urandom);
        send_word(CmdArrival, seq, clock_ms);
      end
    end
  endtask

  initial begin
    quiet = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CmdQuery, 16'h0, 48'h0);
    send_word(CmdArrival, 16'd5, 48'd0);
    send_word(CmdArrival, 16'hFFF0, 48'd1);
    send_word(CmdQuery, 16'hFFFF, 48'd2);
    send_word(CmdQuery, 16'h0, 48'hFFFF_FFFF_FFFF);
    settle();
    load_regs(16'hFFFF, 8'd255, 8'd1);
    send_word(CmdArrival, 16'hFFFF, 48'd100);
    send_word(CmdArrival, 16'h0000, 48'd101);
    send_word(CmdArrival, 16'hFFFE, 48'd102);
    send_word(CmdArrival, 16'h0000, 48'd103);
    send_word(CmdQuery, 16'h0, 48'd103);
    send_word(CmdArrival, 16'h8000, 48'd104);
    send_word(CmdArrival, 16'h0010, 48'd105);
    send_word(CmdArrival, 16'h7FFF, 48'd106);
    send_word(CmdQuery, 16'hFFFF, 48'd107);
    send_word(CmdArrival, 16'h8001, 48'hFFFF_FFFF_0000);
    send_word(CmdQuery, 16'h0, 48'hFFFF_FFFF_0000);
    send_word(CmdQuery, 16'h0, 48'hFFFF_FFFF_FFFF);
    settle();
    load_regs(16'd0, 8'd1, 8'd1);
    send_word(CmdArrival, 16'd10, 48'd200);
    send_word(CmdArrival, 16'd12, 48'd200);
    send_word(CmdQuery, 16'd0, 48'd200);
    send_word(CmdQuery, 16'd0, 48'd201);
    settle();

    clock_ms = 48'd1000;
    seq = 16'($urandom);
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      case (p)
        0: load_regs(16'd4000, 8'd200, 8'd100);
        1: load_regs(16'd0, 8'd1, 8'd1);
        2: load_regs(16'hFFFF, 8'd255, 8'd255);
        3: load_regs(16'd300, 8'd40, 8'd5);
        4: load_regs(16'd1000, 8'd10, 8'd1);
        5: load_regs(16'hFFFF, 8'd255, 8'd1);
        6: load_regs(16'd50, 8'd128, 8'd3);
        default: load_regs(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 30)));
      endcase
      random_phase(140);
      settle();
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
